// ===== rtl/cmp_pkg.sv =====
// ----------------------------------------------------------------------------
// cmp_pkg
// Shared types, codes and tables for the codestream marker parser.
// ----------------------------------------------------------------------------
package cmp_pkg;

  // Width of the running stream offset counter
  localparam int OFFSET_BITS = 32;
  localparam int OFFS_EXT    = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  // Record queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Record kinds
  localparam logic [1:0] KIND_MARKER    = 2'd0;
  localparam logic [1:0] KIND_FIELD     = 2'd1;
  localparam logic [1:0] KIND_UNMATCHED = 2'd2;

  // Marker ids
  localparam logic [2:0] MK_SOC = 3'd0;
  localparam logic [2:0] MK_SOD = 3'd1;
  localparam logic [2:0] MK_SOT = 3'd2;
  localparam logic [2:0] MK_SIZ = 3'd3;
  localparam logic [2:0] MK_COC = 3'd4;
  localparam logic [2:0] MK_COD = 3'd5;
  localparam logic [2:0] MK_COM = 3'd6;
  localparam logic [2:0] MK_EOC = 3'd7;

  // Marker prefix and second bytes
  localparam logic [7:0] CODE_PREFIX = 8'hFF;
  localparam logic [7:0] CODE_SOC    = 8'h4F;
  localparam logic [7:0] CODE_SOD    = 8'h93;
  localparam logic [7:0] CODE_SOT    = 8'h90;
  localparam logic [7:0] CODE_SIZ    = 8'h51;
  localparam logic [7:0] CODE_COC    = 8'h53;
  localparam logic [7:0] CODE_COD    = 8'h52;
  localparam logic [7:0] CODE_COM    = 8'h64;
  localparam logic [7:0] CODE_EOC    = 8'hD9;

  // Field ids where the segment walk branches
  localparam logic [3:0] FLD_LEN      = 4'd0;
  localparam logic [3:0] FLD_TNSOT    = 4'd4;
  localparam logic [3:0] FLD_CSIZ     = 4'd10;
  localparam logic [3:0] FLD_SSIZ     = 4'd11;
  localparam logic [3:0] FLD_YRSIZ    = 4'd13;
  localparam logic [3:0] FLD_SGCOD    = 4'd2;
  localparam logic [3:0] FLD_SPCOD    = 4'd3;
  localparam logic [3:0] FLD_RCOM     = 4'd1;
  localparam logic [3:0] FLD_CCOM     = 4'd2;

  // Header bytes not counted in a body length
  localparam logic [15:0] COD_HDR_LEN = 16'd7;
  localparam logic [15:0] COM_HDR_LEN = 16'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  marker;
    logic [3:0]  field;
    logic [13:0] comp;
    logic [31:0] value;
    logic [31:0] offset;
    logic        last;
  } rec_t;

  typedef struct packed {
    rec_t       r0;
    rec_t       r1;
    logic [1:0] n;
  } rec_pair_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] id;
  } marker_hit_t;

  // Byte width of each segment field, zero where no field exists
  function automatic logic [2:0] field_width(input logic [2:0] m, input logic [3:0] f);
    logic [2:0] w;
    w = 3'd0;
    case (m)
      MK_SOT: begin
        case (f)
          4'd0, 4'd1: w = 3'd2;
          4'd2:       w = 3'd4;
          4'd3, 4'd4: w = 3'd1;
          default:    w = 3'd0;
        endcase
      end
      MK_SIZ: begin
        case (f)
          4'd0, 4'd1, 4'd10:  w = 3'd2;
          4'd11, 4'd12, 4'd13: w = 3'd1;
          4'd14, 4'd15:       w = 3'd0;
          default:            w = 3'd4;
        endcase
      end
      MK_COD: begin
        case (f)
          4'd0:       w = 3'd2;
          4'd1, 4'd3: w = 3'd1;
          4'd2:       w = 3'd4;
          default:    w = 3'd0;
        endcase
      end
      MK_COM: begin
        case (f)
          4'd0, 4'd1: w = 3'd2;
          4'd2:       w = 3'd1;
          default:    w = 3'd0;
        endcase
      end
      default: w = 3'd0;
    endcase
    return w;
  endfunction

  function automatic marker_hit_t marker_lookup(input logic [7:0] b);
    marker_hit_t h;
    h.hit = 1'b1;
    h.id  = MK_SOC;
    case (b)
      CODE_SOC: h.id = MK_SOC;
      CODE_SOD: h.id = MK_SOD;
      CODE_SOT: h.id = MK_SOT;
      CODE_SIZ: h.id = MK_SIZ;
      CODE_COC: h.id = MK_COC;
      CODE_COD: h.id = MK_COD;
      CODE_COM: h.id = MK_COM;
      CODE_EOC: h.id = MK_EOC;
      default:  h.hit = 1'b0;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rec_offset(input logic [OFFSET_BITS-1:0] v);
    logic [OFFS_EXT-1:0] e;
    e = OFFS_EXT'(v);
    return e[31:0];
  endfunction

  function automatic rec_t make_rec(input logic [1:0] kind, input logic [2:0] marker,
                                    input logic [3:0] field, input logic [13:0] comp,
                                    input logic [31:0] value,
                                    input logic [OFFSET_BITS-1:0] offset);
    rec_t r;
    r.kind   = kind;
    r.marker = marker;
    r.field  = field;
    r.comp   = comp;
    r.value  = value;
    r.offset = rec_offset(offset);
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/cmp_parser.sv =====
// ----------------------------------------------------------------------------
// cmp_parser
// Parse state and per-byte decode: marker match, field gather and segment walk.
// ----------------------------------------------------------------------------
module cmp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              end_of_stream,
  output cmp_pkg::rec_pair_t recs
);
  import cmp_pkg::*;

  logic [7:0]             pending_byte, pending_byte_next;
  logic                   pending_valid, pending_valid_next;
  logic [2:0]             phase_marker, phase_marker_next;
  logic [3:0]             phase_field, phase_field_next;
  logic [2:0]             field_byte_count, field_byte_count_next;
  logic [31:0]            field_accumulator, field_accumulator_next;
  logic [15:0]            segment_length, segment_length_next;
  logic [15:0]            bytes_remaining, bytes_remaining_next;
  logic [15:0]            component_total, component_total_next;
  logic [13:0]            component_counter, component_counter_next;
  logic [OFFSET_BITS-1:0] stream_offset, stream_offset_next;

  logic                   phase_active;
  logic [2:0]             width;
  logic [2:0]             cnt_inc;
  logic [31:0]            acc_shift;
  logic [OFFSET_BITS-1:0] prev_offset;
  logic [OFFSET_BITS-1:0] field_offset;
  logic [15:0]            cod_body;
  logic [15:0]            com_body;
  logic [15:0]            rem_dec;
  logic [15:0]            total_dec;
  logic [13:0]            field_comp;
  marker_hit_t            lookup;

  assign phase_active = (phase_marker != MK_SOC) || (phase_field != FLD_LEN);
  assign width        = field_width(phase_marker, phase_field);
  assign cnt_inc      = field_byte_count + 3'd1;
  assign acc_shift    = {field_accumulator[23:0], data_byte};
  assign prev_offset  = stream_offset - OFFSET_BITS'(1);
  assign field_offset = stream_offset - OFFSET_BITS'(width - 3'd1);
  assign cod_body     = (segment_length > COD_HDR_LEN) ? segment_length - COD_HDR_LEN : 16'd0;
  assign com_body     = (segment_length > COM_HDR_LEN) ? segment_length - COM_HDR_LEN : 16'd0;
  assign rem_dec      = bytes_remaining - 16'd1;
  assign total_dec    = component_total - 16'd1;
  assign field_comp   = (phase_marker == MK_SIZ && phase_field >= FLD_SSIZ) ?
                        component_counter : 14'd0;
  assign lookup       = marker_lookup(data_byte);

  always_comb begin
    pending_byte_next      = pending_byte;
    pending_valid_next     = pending_valid;
    phase_marker_next      = phase_marker;
    phase_field_next       = phase_field;
    field_byte_count_next  = field_byte_count;
    field_accumulator_next = field_accumulator;
    segment_length_next    = segment_length;
    bytes_remaining_next   = bytes_remaining;
    component_total_next   = component_total;
    component_counter_next = component_counter;
    stream_offset_next     = stream_offset;
    recs                   = '0;

    if (take) begin
      stream_offset_next = stream_offset + OFFSET_BITS'(1);

      if (phase_active && width != 3'd0) begin
        field_accumulator_next = acc_shift;
        field_byte_count_next  = cnt_inc;
        if (cnt_inc >= width) begin
          recs.r0 = make_rec(KIND_FIELD, phase_marker, phase_field, field_comp,
                             acc_shift, field_offset);
          recs.n  = 2'd1;
          field_accumulator_next = '0;
          field_byte_count_next  = '0;
          if (phase_field == FLD_LEN) begin
            segment_length_next = acc_shift[15:0];
          end
          // walk to the next field of the segment
          case (phase_marker)
            MK_SOT: begin
              if (phase_field < FLD_TNSOT) begin
                phase_field_next = phase_field + 4'd1;
              end else begin
                phase_marker_next = MK_SOC;
                phase_field_next  = FLD_LEN;
              end
            end
            MK_SIZ: begin
              if (phase_field < FLD_CSIZ) begin
                phase_field_next = phase_field + 4'd1;
              end else if (phase_field == FLD_CSIZ) begin
                component_total_next   = acc_shift[15:0];
                component_counter_next = '0;
                if (acc_shift[15:0] == 16'd0) begin
                  phase_marker_next = MK_SOC;
                  phase_field_next  = FLD_LEN;
                end else begin
                  phase_field_next = FLD_SSIZ;
                end
              end else if (phase_field < FLD_YRSIZ) begin
                phase_field_next = phase_field + 4'd1;
              end else begin
                component_counter_next = component_counter + 14'd1;
                component_total_next   = total_dec;
                if (total_dec == 16'd0) begin
                  phase_marker_next = MK_SOC;
                  phase_field_next  = FLD_LEN;
                end else begin
                  phase_field_next = FLD_SSIZ;
                end
              end
            end
            MK_COD: begin
              if (phase_field < FLD_SGCOD) begin
                phase_field_next = phase_field + 4'd1;
              end else if (phase_field == FLD_SGCOD) begin
                bytes_remaining_next = cod_body;
                if (cod_body == 16'd0) begin
                  phase_marker_next = MK_SOC;
                  phase_field_next  = FLD_LEN;
                end else begin
                  phase_field_next = FLD_SPCOD;
                end
              end else begin
                bytes_remaining_next = rem_dec;
                if (rem_dec == 16'd0) begin
                  phase_marker_next = MK_SOC;
                  phase_field_next  = FLD_LEN;
                end
              end
            end
            MK_COM: begin
              if (phase_field == FLD_LEN) begin
                phase_field_next = FLD_RCOM;
              end else if (phase_field == FLD_RCOM) begin
                bytes_remaining_next = com_body;
                if (com_body == 16'd0) begin
                  phase_marker_next = MK_SOC;
                  phase_field_next  = FLD_LEN;
                end else begin
                  phase_field_next = FLD_CCOM;
                end
              end else begin
                bytes_remaining_next = rem_dec;
                if (rem_dec == 16'd0) begin
                  phase_marker_next = MK_SOC;
                  phase_field_next  = FLD_LEN;
                end
              end
            end
            default: begin
              phase_marker_next = MK_SOC;
              phase_field_next  = FLD_LEN;
            end
          endcase
        end
      end else begin
        phase_marker_next = MK_SOC;
        phase_field_next  = FLD_LEN;
        if (pending_valid && pending_byte == CODE_PREFIX && lookup.hit) begin
          recs.r0 = make_rec(KIND_MARKER, lookup.id, FLD_LEN, 14'd0,
                             {16'd0, CODE_PREFIX, data_byte}, prev_offset);
          recs.n  = 2'd1;
          pending_valid_next     = 1'b0;
          pending_byte_next      = '0;
          field_accumulator_next = '0;
          field_byte_count_next  = '0;
          if (lookup.id == MK_SOT || lookup.id == MK_SIZ ||
              lookup.id == MK_COD || lookup.id == MK_COM) begin
            phase_marker_next = lookup.id;
          end
        end else begin
          if (pending_valid) begin
            recs.r0 = make_rec(KIND_UNMATCHED, MK_SOC, FLD_LEN, 14'd0,
                               {24'd0, pending_byte}, prev_offset);
          end
          if (end_of_stream) begin
            // flush the final byte behind any pending one
            if (pending_valid) begin
              recs.r1 = make_rec(KIND_UNMATCHED, MK_SOC, FLD_LEN, 14'd0,
                                 {24'd0, data_byte}, stream_offset);
              recs.n  = 2'd2;
            end else begin
              recs.r0 = make_rec(KIND_UNMATCHED, MK_SOC, FLD_LEN, 14'd0,
                                 {24'd0, data_byte}, stream_offset);
              recs.n  = 2'd1;
            end
            pending_valid_next = 1'b0;
            pending_byte_next  = '0;
          end else begin
            recs.n             = pending_valid ? 2'd1 : 2'd0;
            pending_byte_next  = data_byte;
            pending_valid_next = 1'b1;
          end
        end
      end

      if (end_of_stream) begin
        phase_marker_next      = MK_SOC;
        phase_field_next       = FLD_LEN;
        pending_valid_next     = 1'b0;
        pending_byte_next      = '0;
        field_accumulator_next = '0;
        field_byte_count_next  = '0;
      end

      if (recs.n == 2'd1) begin
        recs.r0.last = 1'b1;
      end
      if (recs.n == 2'd2) begin
        recs.r1.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_byte      <= '0;
      pending_valid     <= 1'b0;
      phase_marker      <= MK_SOC;
      phase_field       <= FLD_LEN;
      field_byte_count  <= '0;
      field_accumulator <= '0;
      segment_length    <= '0;
      bytes_remaining   <= '0;
      component_total   <= '0;
      component_counter <= '0;
      stream_offset     <= '0;
    end else begin
      pending_byte      <= pending_byte_next;
      pending_valid     <= pending_valid_next;
      phase_marker      <= phase_marker_next;
      phase_field       <= phase_field_next;
      field_byte_count  <= field_byte_count_next;
      field_accumulator <= field_accumulator_next;
      segment_length    <= segment_length_next;
      bytes_remaining   <= bytes_remaining_next;
      component_total   <= component_total_next;
      component_counter <= component_counter_next;
      stream_offset     <= stream_offset_next;
    end
  end

  // a live segment phase always names a real field
  a_phase_has_field: assert property (@(posedge clk) disable iff (rst)
    phase_active |-> (width != 3'd0))
    else $error("segment phase points at no field");

  // a byte is held back only while scanning
  a_pending_scan: assert property (@(posedge clk) disable iff (rst)
    pending_valid |-> !phase_active)
    else $error("pending byte held inside a segment");

  // per-component SIZ fields only run with components left
  a_siz_components: assert property (@(posedge clk) disable iff (rst)
    (phase_marker == MK_SIZ && phase_field >= FLD_SSIZ) |-> (component_total != 16'd0))
    else $error("SIZ component phase with no components left");

endmodule

// ===== rtl/cmp_outq.sv =====
// ----------------------------------------------------------------------------
// cmp_outq
// Small record queue: takes up to two records per cycle, hands out one.
// ----------------------------------------------------------------------------
module cmp_outq (
  input  logic               clk,
  input  logic               rst,
  input  cmp_pkg::rec_pair_t recs,
  input  logic               pop,
  output cmp_pkg::rec_t      head,
  output logic               not_empty,
  output logic               low_room
);
  import cmp_pkg::*;

  rec_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [QPTR_W-1:0] wr_ptr_inc;
  logic [QPTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [QCNT_W-1:0] count, count_next;

  assign wr_ptr_inc  = wr_ptr + QPTR_W'(1);
  assign wr_ptr_next = wr_ptr + QPTR_W'(recs.n);
  assign rd_ptr_next = pop ? rd_ptr + QPTR_W'(1) : rd_ptr;
  assign count_next  = count + QCNT_W'(recs.n) - QCNT_W'(pop);

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  // hold off input unless two slots are free
  assign low_room  = (count > QCNT_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (recs.n != 2'd0) begin
      mem[wr_ptr] <= recs.r0;
    end
    if (recs.n == 2'd2) begin
      mem[wr_ptr_inc] <= recs.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("record queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (recs.n != 2'd0) |-> (count <= QCNT_W'(QDEPTH - 2)))
    else $error("records pushed without room for two");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("record popped from empty queue");

endmodule

// ===== rtl/codestream_marker_parser.sv =====
// ----------------------------------------------------------------------------
// codestream_marker_parser
// Byte-wide JPEG 2000 codestream marker and segment field parser.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  data_byte, end_of_stream
//   output   out        out_valid/out_stall  record_kind .. last_of_run
//
// One byte is decoded in the cycle it is accepted; its records enter a
// four-entry queue that hands out one record per cycle unless out_stall
// is high. Bytes yielding one record stream at one per cycle when no stall
// is raised; a byte with two records sends them one at a time out of the
// single-record output port. Reset is synchronous, with no clearing pass;
// in_stall rises while over two records wait, so output stalls back up.
// ----------------------------------------------------------------------------
module codestream_marker_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  record_kind,
  output logic [2:0]  marker_id,
  output logic [3:0]  field_id,
  output logic [13:0] component_number,
  output logic [31:0] field_value,
  output logic [31:0] byte_offset,
  output logic        last_of_run
);
  import cmp_pkg::*;

  rec_pair_t recs;
  rec_t      head;
  logic      take;
  logic      pop;
  logic      low_room;

  assign in_stall = low_room;
  assign take     = in_valid && !low_room;
  assign pop      = out_valid && !out_stall;

  cmp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .recs          (recs)
  );

  cmp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .recs      (recs),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .low_room  (low_room)
  );

  assign record_kind      = head.kind;
  assign marker_id        = head.marker;
  assign field_id         = head.field;
  assign component_number = head.comp;
  assign field_value      = head.value;
  assign byte_offset      = head.offset;
  assign last_of_run      = head.last;

endmodule
